@@ hw/rtl/ilad_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed list package
// Shared widths, operation and status codes, and the per-cell control type
// for the bounded ordered list.
// ----------------------------------------------------------------------------
package ilad_pkg;

  // Number of entries in the list store.
  localparam int DEPTH = 16;

  // Field widths.
  localparam int DATA_W  = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  // Operation codes carried by func.
  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_READ   = 2'd1,
    FN_DELETE = 2'd2
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Control for one storage cell in the chain.
  typedef struct packed {
    logic load;   // Take the appended value.
    logic shift;  // Take the value of the next cell up the chain.
  } cell_ctrl_t;

endpackage

@@ hw/rtl/ilad_cell.sv @@
// ----------------------------------------------------------------------------
// Indexed list storage cell
// Holds one list entry. It either loads the appended value, takes the value
// of its upper neighbour when a delete closes the gap, or keeps its value.
// ----------------------------------------------------------------------------
module ilad_cell (
  input  logic                              clk,
  input  ilad_pkg::cell_ctrl_t              ctrl,
  input  logic signed [ilad_pkg::DATA_W-1:0] new_value,
  input  logic signed [ilad_pkg::DATA_W-1:0] next_value,
  output logic signed [ilad_pkg::DATA_W-1:0] value
);

  logic signed [ilad_pkg::DATA_W-1:0] value_r;
  logic signed [ilad_pkg::DATA_W-1:0] value_nxt;

  // Select the next content of the cell; the two controls never coincide.
  always_comb begin
    priority if (ctrl.shift) begin
      value_nxt = next_value;
    end else if (ctrl.load) begin
      value_nxt = new_value;
    end else begin
      value_nxt = value_r;
    end
  end

  // Entry storage; contents are undefined until written.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

@@ hw/rtl/indexed_list_append_get_delete.sv @@
// ----------------------------------------------------------------------------
// Indexed list with append, read and delete
// Bounded ordered list held in a chain of storage cells. Append writes the
// cell at the tail, delete shifts every later cell down by one place, and
// read selects the cell at the requested position.
// ----------------------------------------------------------------------------
// A result is presented in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless stalled; every cell updates in the same cycle.
// A new transaction is accepted while the output register is empty or is being
// taken in the same cycle.
// Reset clears the entry count and the output valid; the cells are not cleared.
module indexed_list_append_get_delete (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic [ilad_pkg::POS_W-1:0]         in_position,
  input  logic signed [ilad_pkg::DATA_W-1:0] in_new_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ilad_pkg::DATA_W-1:0] out_read_value,
  output logic [1:0]                         out_status,
  output logic [ilad_pkg::COUNT_W-1:0]       out_entry_count
);

  localparam int DEPTH   = ilad_pkg::DEPTH;
  localparam int DATA_W  = ilad_pkg::DATA_W;
  localparam int COUNT_W = ilad_pkg::COUNT_W;
  localparam int POS_W   = ilad_pkg::POS_W;

  logic                       in_acc;
  logic [COUNT_W-1:0]         count_r;
  logic [COUNT_W-1:0]         count_nxt;
  logic [COUNT_W-1:0]         pos_ext;
  logic                       in_range;
  logic                       not_full;
  logic                       append_ok;
  logic                       delete_ok;
  logic                       read_ok;
  ilad_pkg::status_t          status_nxt;
  logic signed [DATA_W-1:0]   read_value_nxt;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic signed [DATA_W-1:0]   out_read_value_r;
  ilad_pkg::status_t          out_status_r;
  logic [COUNT_W-1:0]         out_entry_count_r;

  ilad_pkg::cell_ctrl_t       cell_ctrl [DEPTH];
  logic signed [DATA_W-1:0]   entry_q   [DEPTH];
  logic signed [DATA_W-1:0]   next_q    [DEPTH];

  // Handshake: the output register parts the two channels.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // Decode the request against the current count.
  assign pos_ext  = {{(COUNT_W-POS_W){1'b0}}, in_position};
  assign in_range = pos_ext < count_r;
  assign not_full = count_r < COUNT_W'(DEPTH);

  always_comb begin
    append_ok      = 1'b0;
    delete_ok      = 1'b0;
    read_ok        = 1'b0;
    status_nxt     = ilad_pkg::ST_OK;
    unique case (ilad_pkg::func_t'(in_func))
      ilad_pkg::FN_APPEND: begin
        append_ok  = in_acc & not_full;
        status_nxt = not_full ? ilad_pkg::ST_OK : ilad_pkg::ST_FULL;
      end
      ilad_pkg::FN_READ: begin
        read_ok    = in_range;
        status_nxt = in_range ? ilad_pkg::ST_OK : ilad_pkg::ST_RANGE;
      end
      ilad_pkg::FN_DELETE: begin
        delete_ok  = in_acc & in_range;
        status_nxt = in_range ? ilad_pkg::ST_OK : ilad_pkg::ST_RANGE;
      end
      default: begin
        status_nxt = ilad_pkg::ST_OK;
      end
    endcase
  end

  // Read selects the cell at the requested position.
  assign read_value_nxt = read_ok ? entry_q[in_position] : '0;

  // Entry count after the operation.
  always_comb begin
    priority if (append_ok) begin
      count_nxt = count_r + COUNT_W'(1);
    end else if (delete_ok) begin
      count_nxt = count_r - COUNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // Chain of storage cells, each fed by its upper neighbour; the top cell keeps its own value.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_top
      assign next_q[i] = entry_q[i];
    end else begin : g_mid
      assign next_q[i] = entry_q[i+1];
    end

    assign cell_ctrl[i].load  = append_ok & (count_r == COUNT_W'(i));
    assign cell_ctrl[i].shift = delete_ok & (COUNT_W'(i) >= pos_ext)
                              & (COUNT_W'(i + 1) < count_r);

    ilad_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .new_value  (in_new_value),
      .next_value (next_q[i]),
      .value      (entry_q[i])
    );
  end

  // Output valid: set by an accepted transaction, cleared when taken.
  always_comb begin
    priority if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_read_value_r  <= read_value_nxt;
      out_status_r      <= status_nxt;
      out_entry_count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;

  // The count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // A successful append raises the count by one.
  a_append_inc: assert property (@(posedge clk) disable iff (!rst_n)
    append_ok |=> count_r == $past(count_r) + COUNT_W'(1))
    else $error("append did not increment count");

  // A full status is only reported with a full store.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ilad_pkg::ST_FULL) |-> out_entry_count == COUNT_W'(DEPTH))
    else $error("full status with store not full");

  // A failed request returns a zero read value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ilad_pkg::ST_OK) |-> out_read_value == '0)
    else $error("non-zero read value on failed request");

endmodule
